### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the collision response block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CFCR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: property failed");

`define CFCR_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define CFCR_ASSERT(lbl, clk, rstn, prop)

`define CFCR_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### sv/cfcr_pkg.sv
// ----------------------------------------------------------------------------
// cfcr_pkg
// shared types, constants and helpers of the collision response block
// ----------------------------------------------------------------------------
package cfcr_pkg;

  localparam logic [31:0] FRICTION_RESET = 32'd19688456;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_UNCHANGED = 2'd0,
    KIND_STICK     = 2'd1,
    KIND_SLIDE     = 2'd2
  } response_kind_e;

  // classified item handed from the front to the back
  typedef struct packed {
    logic        collide;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] neg_vn;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] vx;
    logic [31:0] vy;
  } front_item_t;

  typedef struct packed {
    logic        valid;
    front_item_t item;
  } item_xfer_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### sv/cfcr_in_if.sv
// ----------------------------------------------------------------------------
// cfcr_in_if
// input stream: point velocity, body velocity, normal and distance
// ----------------------------------------------------------------------------
interface cfcr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] body_vel_x;
  logic signed [31:0] body_vel_y;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [31:0] signed_distance;

  modport source (
    output valid, vel_x, vel_y, body_vel_x, body_vel_y, normal_x, normal_y,
           signed_distance,
    input  ready
  );
  modport sink (
    input  valid, vel_x, vel_y, body_vel_x, body_vel_y, normal_x, normal_y,
           signed_distance,
    output ready
  );
endinterface

### sv/cfcr_out_if.sv
// ----------------------------------------------------------------------------
// cfcr_out_if
// result stream: resulting velocity and response kind
// ----------------------------------------------------------------------------
interface cfcr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic        [1:0]  response_kind;

  modport source (
    output valid, out_vel_x, out_vel_y, response_kind,
    input  ready
  );
  modport sink (
    input  valid, out_vel_x, out_vel_y, response_kind,
    output ready
  );
endinterface

### sv/cfcr_front.sv
// ----------------------------------------------------------------------------
// cfcr_front
// accepts items, forms relative and tangential velocity, flags collisions
// ----------------------------------------------------------------------------
module cfcr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  cfcr_in_if.sink             in_i,
  input  logic                q_full_i,
  output cfcr_pkg::item_xfer_t push_o
);
  import cfcr_pkg::*;

  typedef struct packed {
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] vx;
    logic [31:0] vy;
  } pass_t;

  logic       en;
  logic [3:0] vf_q;

  // stage 1: relative velocity
  logic signed [32:0] f1_rx_q, f1_ry_q;
  logic signed [15:0] f1_nx_q, f1_ny_q;
  logic               f1_dle_q;
  pass_t              f1_p_q;
  // stage 2: normal products
  logic signed [48:0] f2_prx_q, f2_pry_q;
  logic signed [32:0] f2_rx_q, f2_ry_q;
  logic signed [15:0] f2_nx_q, f2_ny_q;
  logic               f2_dle_q;
  pass_t              f2_p_q;
  // stage 3: normal speed
  logic signed [49:0] vn_raw, vn_rnd, vn_sh;
  logic signed [31:0] f3_vn_q;
  logic               f3_col_q;
  logic signed [32:0] f3_rx_q, f3_ry_q;
  logic signed [15:0] f3_nx_q, f3_ny_q;
  pass_t              f3_p_q;
  // stage 4: normal part of the relative velocity
  logic signed [47:0] f4_pnx_q, f4_pny_q;
  logic signed [31:0] f4_vn_q;
  logic               f4_col_q;
  logic signed [32:0] f4_rx_q, f4_ry_q;
  pass_t              f4_p_q;

  logic signed [47:0] snx, sny;

  assign en         = !vf_q[3] || !q_full_i;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else if (en) begin
      vf_q <= {vf_q[2:0], in_i.valid};
    end
  end

  always_comb begin
    vn_raw = 50'(f2_prx_q) + 50'(f2_pry_q);
    vn_rnd = vn_raw + 50'sd8192;
    vn_sh  = vn_rnd >>> 14;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_rx_q  <= 33'(in_i.vel_x) - 33'(in_i.body_vel_x);
      f1_ry_q  <= 33'(in_i.vel_y) - 33'(in_i.body_vel_y);
      f1_nx_q  <= in_i.normal_x;
      f1_ny_q  <= in_i.normal_y;
      f1_dle_q <= in_i.signed_distance <= 32'sd0;
      f1_p_q   <= '{bx: in_i.body_vel_x, by: in_i.body_vel_y,
                    vx: in_i.vel_x, vy: in_i.vel_y};

      f2_prx_q <= 49'(f1_rx_q) * 49'(f1_nx_q);
      f2_pry_q <= 49'(f1_ry_q) * 49'(f1_ny_q);
      f2_rx_q  <= f1_rx_q;
      f2_ry_q  <= f1_ry_q;
      f2_nx_q  <= f1_nx_q;
      f2_ny_q  <= f1_ny_q;
      f2_dle_q <= f1_dle_q;
      f2_p_q   <= f1_p_q;

      f3_vn_q  <= $signed(sat32(64'(vn_sh)));
      f3_col_q <= f2_dle_q && (vn_raw < 50'sd0);
      f3_rx_q  <= f2_rx_q;
      f3_ry_q  <= f2_ry_q;
      f3_nx_q  <= f2_nx_q;
      f3_ny_q  <= f2_ny_q;
      f3_p_q   <= f2_p_q;

      f4_pnx_q <= 48'(f3_nx_q) * 48'(f3_vn_q);
      f4_pny_q <= 48'(f3_ny_q) * 48'(f3_vn_q);
      f4_vn_q  <= f3_vn_q;
      f4_col_q <= f3_col_q;
      f4_rx_q  <= f3_rx_q;
      f4_ry_q  <= f3_ry_q;
      f4_p_q   <= f3_p_q;
    end
  end

  always_comb begin
    snx = (f4_pnx_q + 48'sd8192) >>> 14;
    sny = (f4_pny_q + 48'sd8192) >>> 14;
    push_o.valid        = vf_q[3] && en;
    push_o.item.collide = f4_col_q;
    push_o.item.tx      = sat32(64'(f4_rx_q) - 64'(snx));
    push_o.item.ty      = sat32(64'(f4_ry_q) - 64'(sny));
    push_o.item.neg_vn  = f4_vn_q[31] ? 32'(-{f4_vn_q[31], f4_vn_q}) : 32'd0;
    push_o.item.bx      = f4_p_q.bx;
    push_o.item.by      = f4_p_q.by;
    push_o.item.vx      = f4_p_q.vx;
    push_o.item.vy      = f4_p_q.vy;
  end

endmodule

### sv/cfcr_queue.sv
// ----------------------------------------------------------------------------
// cfcr_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfcr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfcr_pkg::item_xfer_t push_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output cfcr_pkg::item_xfer_t head_o
);
  import cfcr_pkg::*;

  front_item_t      mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push   = push_i.valid;
  assign pop    = pop_i;
  assign full_o = count_q == CNT_W'(QDEPTH);
  assign head_o.valid = count_q != '0;
  assign head_o.item  = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push) begin
      wr_d = (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i.item;
    end
  end

  `CFCR_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push && full_o)
  `CFCR_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop && !head_o.valid)
  `CFCR_ASSERT(a_count_up, clk_i, rst_ni, (push && !pop) |=> count_q == $past(count_q) + CNT_W'(1))

endmodule

### sv/cfcr_back.sv
// ----------------------------------------------------------------------------
// cfcr_back
// friction projection: tangential length, stick test, scaling, body add-back
// ----------------------------------------------------------------------------
module cfcr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          friction_i,
  input  cfcr_pkg::item_xfer_t head_i,
  output logic                 pop_o,
  cfcr_out_if.source           out_o
);
  import cfcr_pkg::*;

  typedef struct packed {
    logic        collide;
    logic        sx;
    logic        sy;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [63:0] prod;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] vx;
    logic [31:0] vy;
  } sq_side_t;

  typedef struct packed {
    logic        collide;
    logic        stick;
    logic        sx;
    logic        sy;
    logic [31:0] len;
    logic [31:0] bx;
    logic [31:0] by;
    logic [31:0] vx;
    logic [31:0] vy;
  } dv_side_t;

  logic en;

  logic        b1_v_q, b2_v_q;
  sq_side_t    b1_q, b2_q;
  logic [63:0] b2_sqx_q, b2_sqy_q;

  logic        sq_v_q    [0:32];
  logic [32:0] sq_rem_q  [0:32];
  logic [31:0] sq_root_q [0:32];
  logic [63:0] sq_rad_q  [0:32];
  sq_side_t    sq_side_q [0:32];

  logic        c1_v_q, c2_v_q;
  dv_side_t    c1_q, c2_q;
  logic [31:0] c1_keep_q, c1_ax_q, c1_ay_q;
  logic [63:0] c2_nx_q, c2_ny_q;

  logic        dv_v_q    [0:32];
  logic [31:0] dx_rem_q  [0:32];
  logic [31:0] dx_lo_q   [0:32];
  logic [31:0] dx_quo_q  [0:32];
  logic [31:0] dy_rem_q  [0:32];
  logic [31:0] dy_lo_q   [0:32];
  logic [31:0] dy_quo_q  [0:32];
  dv_side_t    dv_side_q [0:32];

  logic           out_v_q;
  logic [31:0]    out_x_q, out_y_q;
  response_kind_e out_kind_q;

  // stage c1 and final stage combinational terms
  sq_side_t    c1_in;
  logic [31:0] c1_len;
  logic [47:0] c1_d;
  logic [31:0] c1_keep;
  logic        c1_stick;
  dv_side_t    fin;
  logic [33:0] qx_s, qy_s;
  logic [31:0] res_x, res_y;

  assign en          = !out_v_q || out_o.ready;
  assign pop_o       = en && head_i.valid;
  assign out_o.valid = out_v_q;
  assign out_o.out_vel_x     = $signed(out_x_q);
  assign out_o.out_vel_y     = $signed(out_y_q);
  assign out_o.response_kind = out_kind_q;

  // front stages: magnitudes, friction bound, squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q    <= 1'b0;
      b2_v_q    <= 1'b0;
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      b1_v_q    <= head_i.valid;
      b2_v_q    <= b1_v_q;
      sq_v_q[0] <= b2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q.collide <= head_i.item.collide;
      b1_q.sx      <= head_i.item.tx[31];
      b1_q.sy      <= head_i.item.ty[31];
      b1_q.ax      <= head_i.item.tx[31] ? (~head_i.item.tx + 32'd1) : head_i.item.tx;
      b1_q.ay      <= head_i.item.ty[31] ? (~head_i.item.ty + 32'd1) : head_i.item.ty;
      b1_q.prod    <= 64'(friction_i) * 64'(head_i.item.neg_vn);
      b1_q.bx      <= head_i.item.bx;
      b1_q.by      <= head_i.item.by;
      b1_q.vx      <= head_i.item.vx;
      b1_q.vy      <= head_i.item.vy;

      b2_q     <= b1_q;
      b2_sqx_q <= 64'(b1_q.ax) * 64'(b1_q.ax);
      b2_sqy_q <= 64'(b1_q.ay) * 64'(b1_q.ay);

      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_rad_q[0]  <= b2_sqx_q + b2_sqy_q;
      sq_side_q[0] <= b2_q;
    end
  end

  // integer square root, one result bit per stage
  for (genvar g = 0; g < 32; g++) begin : g_sqrt
    logic [34:0] r2, trial, diff;
    logic        ge;

    always_comb begin
      r2    = {sq_rem_q[g], sq_rad_q[g][63:62]};
      trial = {1'b0, sq_root_q[g], 2'b01};
      diff  = r2 - trial;
      ge    = r2 >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[g+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[g+1] <= sq_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[g+1]  <= ge ? diff[32:0] : r2[32:0];
        sq_root_q[g+1] <= {sq_root_q[g][30:0], ge};
        sq_rad_q[g+1]  <= {sq_rad_q[g][61:0], 2'b00};
        sq_side_q[g+1] <= sq_side_q[g];
      end
    end
  end

  // stick test and kept tangential length
  always_comb begin
    c1_in    = sq_side_q[32];
    c1_len   = sq_root_q[32];
    c1_stick = {16'd0, c1_len, 16'd0} <= c1_in.prod;
    c1_d     = 48'((c1_in.prod + 64'h8000) >> 16);
    c1_keep  = ({16'd0, c1_len} > c1_d) ? (c1_len - c1_d[31:0]) : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_v_q    <= 1'b0;
      c2_v_q    <= 1'b0;
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      c1_v_q    <= sq_v_q[32];
      c2_v_q    <= c1_v_q;
      dv_v_q[0] <= c2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q.collide <= c1_in.collide;
      c1_q.stick   <= c1_stick;
      c1_q.sx      <= c1_in.sx;
      c1_q.sy      <= c1_in.sy;
      c1_q.len     <= c1_len;
      c1_q.bx      <= c1_in.bx;
      c1_q.by      <= c1_in.by;
      c1_q.vx      <= c1_in.vx;
      c1_q.vy      <= c1_in.vy;
      c1_keep_q    <= c1_keep;
      c1_ax_q      <= c1_in.ax;
      c1_ay_q      <= c1_in.ay;

      c2_q    <= c1_q;
      c2_nx_q <= 64'(c1_ax_q) * 64'(c1_keep_q);
      c2_ny_q <= 64'(c1_ay_q) * 64'(c1_keep_q);

      // rounding term added ahead of the divide
      {dx_rem_q[0], dx_lo_q[0]} <= c2_nx_q + 64'(c2_q.len >> 1);
      {dy_rem_q[0], dy_lo_q[0]} <= c2_ny_q + 64'(c2_q.len >> 1);
      dx_quo_q[0]  <= '0;
      dy_quo_q[0]  <= '0;
      dv_side_q[0] <= c2_q;
    end
  end

  // restoring divide by the length, two lanes, one quotient bit per stage
  for (genvar g = 0; g < 32; g++) begin : g_div
    logic [32:0] rx2, ry2, den, dfx, dfy;
    logic        gex, gey;

    always_comb begin
      den = {1'b0, dv_side_q[g].len};
      rx2 = {dx_rem_q[g], dx_lo_q[g][31]};
      ry2 = {dy_rem_q[g], dy_lo_q[g][31]};
      dfx = rx2 - den;
      dfy = ry2 - den;
      gex = rx2 >= den;
      gey = ry2 >= den;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[g+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[g+1] <= dv_v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dx_rem_q[g+1]  <= gex ? dfx[31:0] : rx2[31:0];
        dy_rem_q[g+1]  <= gey ? dfy[31:0] : ry2[31:0];
        dx_lo_q[g+1]   <= {dx_lo_q[g][30:0], 1'b0};
        dy_lo_q[g+1]   <= {dy_lo_q[g][30:0], 1'b0};
        dx_quo_q[g+1]  <= {dx_quo_q[g][30:0], gex};
        dy_quo_q[g+1]  <= {dy_quo_q[g][30:0], gey};
        dv_side_q[g+1] <= dv_side_q[g];
      end
    end
  end

  // sign back, add body velocity, pick the response
  always_comb begin
    fin   = dv_side_q[32];
    qx_s  = fin.sx ? -{2'b00, dx_quo_q[32]} : {2'b00, dx_quo_q[32]};
    qy_s  = fin.sy ? -{2'b00, dy_quo_q[32]} : {2'b00, dy_quo_q[32]};
    res_x = sat32(64'($signed(qx_s)) + 64'($signed(fin.bx)));
    res_y = sat32(64'($signed(qy_s)) + 64'($signed(fin.by)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!fin.collide) begin
        out_x_q    <= fin.vx;
        out_y_q    <= fin.vy;
        out_kind_q <= KIND_UNCHANGED;
      end else if (fin.stick) begin
        out_x_q    <= fin.bx;
        out_y_q    <= fin.by;
        out_kind_q <= KIND_STICK;
      end else begin
        out_x_q    <= res_x;
        out_y_q    <= res_y;
        out_kind_q <= KIND_SLIDE;
      end
    end
  end

endmodule

### sv/coulomb_friction_collision_response_unit.sv
// ----------------------------------------------------------------------------
// coulomb_friction_collision_response_unit
// coulomb friction collision projection of one point velocity per item
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_i      in   valid/ready    vel, body_vel, normal, signed_distance
//  out_o     out  valid/ready    out_vel_x, out_vel_y, response_kind
//  cfg       in   cfg_we_i       friction_coeff (cfg_data_i)
//
// one item per cycle sustained while the output is not stalled; results pass
// through the 32-stage square root and 32-stage divide pipelines
// reset clears all valid state and loads the default friction coefficient
// a stalled output freezes the back pipeline; the four-entry queue lets the
// front keep taking items until it fills
// ----------------------------------------------------------------------------
module coulomb_friction_collision_response_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  cfcr_in_if.sink     in_i,
  cfcr_out_if.source  out_o
);
  import cfcr_pkg::*;

  logic [31:0] friction_q, friction_d;
  item_xfer_t  push, head;
  logic        q_full, pop;

  assign friction_d = cfg_we_i ? cfg_data_i : friction_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      friction_q <= FRICTION_RESET;
    end else begin
      friction_q <= friction_d;
    end
  end

  cfcr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  cfcr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  cfcr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .friction_i (friction_q),
    .head_i     (head),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the coulomb friction collision response unit: a
// short table of directed points then random points, each result compared
// field by field against the table's expected value or an integer projection computed in the bench, over
// several friction coefficients with random stalls on both channels
// ----------------------------------------------------------------------------
module tb;
  import cfcr_pkg::*;

  localparam int unsigned LATENCY = 100;

  typedef struct {
    logic signed [31:0] vx, vy, bx, by;
    logic signed [15:0] nx, ny;
    logic signed [31:0] sdist;
  } point_t;

  typedef struct {
    logic signed [31:0] vx, vy;
    response_kind_e     kind;
  } velocity_t;

  typedef struct {
    point_t    pt;
    bit        typed;
    velocity_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic [31:0] mu;
  bit          no_idle = 1'b0;
  int          n_errors = 0;
  velocity_t   pending_q[$];
  row_t        dir_table[$];

  cfcr_in_if  pt_if ();
  cfcr_out_if res_if ();

  coulomb_friction_collision_response_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (pt_if),
    .out_o      (res_if)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // magnitude scaled by keep/len, rounded half up, sign kept
  function automatic longint shrink(longint t, logic [63:0] keep, logic [63:0] len);
    logic [63:0] m, q;
    m = (t < 0) ? -t : t;
    q = (m * keep + len / 2) / len;
    return (t < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic velocity_t project(point_t p, logic [31:0] coeff);
    velocity_t   r;
    longint      rx, ry, vn_raw, vn, tx, ty;
    logic [63:0] ax, ay, len, neg_vn, prod, d, keep;
    rx = longint'(p.vx) - longint'(p.vy - p.vy) - longint'(p.bx);
    ry = longint'(p.vy) - longint'(p.by);
    vn_raw = rx * longint'(p.nx) + ry * longint'(p.ny);
    r.vx = p.vx;
    r.vy = p.vy;
    r.kind = KIND_UNCHANGED;
    if (p.sdist <= 0 && vn_raw < 0) begin
      vn = clamp32((vn_raw + 8192) >>> 14);
      tx = clamp32(rx - ((longint'(p.nx) * vn + 8192) >>> 14));
      ty = clamp32(ry - ((longint'(p.ny) * vn + 8192) >>> 14));
      ax = (tx < 0) ? -tx : tx;
      ay = (ty < 0) ? -ty : ty;
      len = int_sqrt(ax * ax + ay * ay);
      neg_vn = (vn < 0) ? -vn : 0;
      prod = {32'd0, coeff} * neg_vn;
      if ((len << 16) <= prod) begin
        r.vx = p.bx;
        r.vy = p.by;
        r.kind = KIND_STICK;
      end else begin
        d = (prod + 64'h8000) >> 16;
        keep = (len > d) ? len - d : 0;
        r.vx = 32'(clamp32(shrink(tx, keep, len) + longint'(p.bx)));
        r.vy = 32'(clamp32(shrink(ty, keep, len) + longint'(p.by)));
        r.kind = KIND_SLIDE;
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_vel(int unsigned span);
    return $signed($urandom_range(2 * span)) - $signed(span);
  endfunction

  function automatic point_t random_point();
    point_t      p;
    int unsigned mode;
    mode = $urandom_range(9);
    p.vx = $urandom;
    p.vy = $urandom;
    p.bx = $urandom;
    p.by = $urandom;
    p.nx = 16'($urandom);
    p.ny = 16'($urandom);
    p.sdist = $urandom;
    if (mode >= 2) begin
      // well-formed contact with moderate speeds
      p.vx = rnd_vel(32'h40_0000);
      p.vy = rnd_vel(32'h40_0000);
      p.bx = rnd_vel(32'h10_0000);
      p.by = rnd_vel(32'h10_0000);
      case ($urandom_range(3))
        0: begin p.nx = 16'sd0; p.ny = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384; end
        1: begin p.ny = 16'sd0; p.nx = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384; end
        2: begin
          p.nx = ($urandom_range(1)) ? 16'sd11585 : -16'sd11585;
          p.ny = ($urandom_range(1)) ? 16'sd11585 : -16'sd11585;
        end
        default: begin p.nx = 16'(rnd_vel(16384)); p.ny = 16'(rnd_vel(16384)); end
      endcase
      p.sdist = ($urandom_range(7) == 0) ? 32'sd0 :
                -$signed({12'd0, 20'($urandom_range(20'hFFFFF))});
      if (mode == 9) begin
        // large speeds to drive saturation
        p.vx = $urandom;
        p.vy = $urandom;
      end
    end
    return p;
  endfunction

  task automatic send_point(point_t p);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 22) begin
      pt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pt_if.valid <= 1'b1;
    pt_if.vel_x <= p.vx;
    pt_if.vel_y <= p.vy;
    pt_if.body_vel_x <= p.bx;
    pt_if.body_vel_y <= p.by;
    pt_if.normal_x <= p.nx;
    pt_if.normal_y <= p.ny;
    pt_if.signed_distance <= p.sdist;
    do @(posedge clk_i); while (!pt_if.ready);
    pending_q.push_back(project(p, mu));
  endtask

  task automatic drain();
    @(negedge clk_i);
    pt_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic set_friction(logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    mu = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic row_t mk_row(logic signed [31:0] vx, vy, bx, by,
                                  logic signed [15:0] nx, ny,
                                  logic signed [31:0] sdist, bit typed,
                                  logic signed [31:0] ox, oy, response_kind_e k);
    row_t r;
    r.pt = '{vx, vy, bx, by, nx, ny, sdist};
    r.typed = typed;
    r.res = '{ox, oy, k};
    return r;
  endfunction

  always @(negedge clk_i) begin
    res_if.ready <= no_idle || ($urandom_range(99) >= 22);
  end

  always @(posedge clk_i) begin
    velocity_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected");
        n_errors++;
      end else begin
        e = pending_q.pop_front();
        if (res_if.out_vel_x !== e.vx) begin
          $error("out_vel_x expected %0d got %0d", e.vx, res_if.out_vel_x);
          n_errors++;
        end
        if (res_if.out_vel_y !== e.vy) begin
          $error("out_vel_y expected %0d got %0d", e.vy, res_if.out_vel_y);
          n_errors++;
        end
        if (res_if.response_kind !== e.kind) begin
          $error("response_kind expected %0d got %0d", e.kind, res_if.response_kind);
          n_errors++;
        end
      end
    end
  end

  initial begin
    logic [31:0] coeffs[5];
    row_t        row;
    pt_if.valid = 1'b0;
    pt_if.vel_x = '0;
    pt_if.vel_y = '0;
    pt_if.body_vel_x = '0;
    pt_if.body_vel_y = '0;
    pt_if.normal_x = '0;
    pt_if.normal_y = '0;
    pt_if.signed_distance = '0;
    res_if.ready = 1'b0;
    mu = FRICTION_RESET;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // separating: distance above zero passes velocity through
    dir_table.push_back(mk_row(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, -16'sd16384,
                               1, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, KIND_UNCHANGED));
    dir_table.push_back(mk_row(-32'sd65536, 0, 0, 0, 16'sd16384, 0, 32'sh7FFF_FFFF,
                               1, -32'sd65536, 0, KIND_UNCHANGED));
    // zero normal counts as separating
    dir_table.push_back(mk_row(32'sd12345, -32'sd999, 0, 0, 0, 0, 32'sh8000_0000,
                               1, 32'sd12345, -32'sd999, KIND_UNCHANGED));
    // moving away from the body
    dir_table.push_back(mk_row(0, 32'sd65536, 0, 0, 0, 16'sd16384, 0,
                               1, 0, 32'sd65536, KIND_UNCHANGED));
    // head-on approach, small tangential part from the body: sticks to body velocity
    dir_table.push_back(mk_row(0, -32'sd65536, 32'sd777, -32'sd5, 0, 16'sd16384, 0,
                               1, 32'sd777, -32'sd5, KIND_STICK));
    dir_table.push_back(mk_row(32'sd4000, -32'sd65536, 0, 0, 0, 16'sd16384, -32'sd100,
                               0, 0, 0, KIND_UNCHANGED));
    dir_table.push_back(mk_row(32'sd200000, -32'sd65536, 0, 0, 0, 16'sd16384, -32'sd100,
                               0, 0, 0, KIND_UNCHANGED));
    // tiny approach speed rounds to zero
    dir_table.push_back(mk_row(32'sd1000, -32'sd1, 0, 0, 16'sd0, 16'sd1, 0,
                               0, 0, 0, KIND_UNCHANGED));
    // unnormalised normal
    dir_table.push_back(mk_row(32'sd90000, -32'sd70000, 0, 0, 16'sh7FFF, 16'sh7FFF, -1,
                               0, 0, 0, KIND_UNCHANGED));
    dir_table.push_back(mk_row(32'sd90000, -32'sd70000, 0, 0, 16'sh8000, 16'sh8000, -1,
                               0, 0, 0, KIND_UNCHANGED));
    // extremes that saturate
    dir_table.push_back(mk_row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                               32'sh7FFF_FFFF, 16'sh8000, 16'sh7FFF, 32'sh8000_0000,
                               0, 0, 0, KIND_UNCHANGED));
    dir_table.push_back(mk_row(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                               32'sh8000_0000, 16'sh7FFF, 16'sh8000, 0,
                               0, 0, 0, KIND_UNCHANGED));
    dir_table.push_back(mk_row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_0000,
                               32'sh7FFF_FFFF, 16'sd0, 16'sd16384, -1,
                               0, 0, 0, KIND_UNCHANGED));
    dir_table.push_back(mk_row(32'sd300000, -32'sd300000, 32'sh7FFF_0000, 0,
                               16'sd11585, 16'sd11585, -1, 0, 0, 0, KIND_UNCHANGED));

    no_idle = 1'b1;
    foreach (dir_table[i]) begin
      row = dir_table[i];
      send_point(row.pt);
      if (row.typed) pending_q[pending_q.size() - 1] = row.res;
    end
    drain();
    no_idle = 1'b0;

    coeffs = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_4000, $urandom};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) set_friction(coeffs[ph - 1]);
      for (int k = 0; k < 92; k++) begin
        no_idle = (ph == 2 && k >= 20 && k < 70);
        send_point(random_point());
      end
      no_idle = 1'b0;
      drain();
    end

    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/cfcr_pkg.sv
sv/cfcr_in_if.sv
sv/cfcr_out_if.sv
sv/cfcr_front.sv
sv/cfcr_queue.sv
sv/cfcr_back.sv
sv/coulomb_friction_collision_response_unit.sv
tb/tb.sv
